>>> hdl/tcw_pkg.sv
package tcw_pkg;

  // request codes
  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_PUT_AT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TEXT_ATTR  = 2'd0;
  localparam logic [1:0] CFG_CLEAR_ATTR = 2'd1;

  // character and attribute constants
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  // one cell: attribute in the high byte, character in the low byte
  localparam int CELL_W = 16;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [4:0] row_index;
    logic [6:0] col_index;
  } in_beat_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] read_char;
    logic [7:0] read_attr;
    logic       scrolled;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] text_attr;
    logic [7:0] clear_attr;
  } cfg_t;

endpackage

>>> hdl/tcw_cell_ram.sv
module tcw_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/tcw_ctrl.sv
module tcw_ctrl #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80,
  localparam int ADDR_W = $clog2(SCREEN_ROWS * SCREEN_COLS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tcw_pkg::in_beat_t          in_beat,
  input  tcw_pkg::cfg_t              cfg,
  output logic                       res_valid,
  input  logic                       res_take,
  output tcw_pkg::out_beat_t         res,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
  output logic                       ram_re,
  output logic [ADDR_W-1:0]          ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rdata
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int COL_W      = $clog2(SCREEN_COLS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADDR   = 4'd1;
  localparam logic [3:0] S_PUT    = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_RDW    = 4'd4;
  localparam logic [3:0] S_SCR_RD = 4'd5;
  localparam logic [3:0] S_SCR_WR = 4'd6;
  localparam logic [3:0] S_FILL   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        req_r, req_nxt;
  logic [7:0]        char_r, char_nxt;
  logic [ROW_W-1:0]  pos_row_r, pos_row_nxt;
  logic [COL_W-1:0]  pos_col_r, pos_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CELL_W-1:0] fill_val_r, fill_val_nxt;
  logic              fill_init_r, fill_init_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic [CELL_W-1:0] rd_data_r, rd_data_nxt;

  logic [ADDR_W-1:0] addr_step;
  logic [ADDR_W-1:0] addr_sum;
  logic [ROW_W-1:0]  clamp_row;
  logic [COL_W-1:0]  clamp_col;
  logic              wrap;

  // shared address adder: row stride while fetching a scroll source, else one
  assign addr_step = (state_r == S_SCR_RD) ? ADDR_W'(SCREEN_COLS) : ADDR_W'(1);
  assign addr_sum  = addr_r + addr_step;

  // out-of-range position goes to the last row or column
  assign clamp_row = (32'(in_beat.row_index) > SCREEN_ROWS - 1) ?
                     ROW_W'(SCREEN_ROWS - 1) : ROW_W'(in_beat.row_index);
  assign clamp_col = (32'(in_beat.col_index) > SCREEN_COLS - 1) ?
                     COL_W'(SCREEN_COLS - 1) : COL_W'(in_beat.col_index);

  assign wrap = (char_r == NEWLINE_CODE) || (pos_col_r == COL_W'(SCREEN_COLS - 1));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    char_nxt      = char_r;
    pos_row_nxt   = pos_row_r;
    pos_col_nxt   = pos_col_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    addr_nxt      = addr_r;
    fill_val_nxt  = fill_val_r;
    fill_init_nxt = fill_init_r;
    scrolled_nxt  = scrolled_r;
    rd_data_nxt   = rd_data_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = fill_val_r;
    ram_re        = 1'b0;
    ram_raddr     = addr_r;
    res_valid     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_beat.req_type;
          char_nxt     = in_beat.char_code;
          scrolled_nxt = 1'b0;
          rd_data_nxt  = '0;
          case (in_beat.req_type)
            REQ_PUT: begin
              pos_row_nxt = cur_row_r;
              pos_col_nxt = cur_col_r;
              state_nxt   = S_ADDR;
            end
            REQ_CLEAR: begin
              addr_nxt      = '0;
              fill_val_nxt  = {cfg.clear_attr, SPACE_CODE};
              fill_init_nxt = 1'b0;
              cur_row_nxt   = '0;
              cur_col_nxt   = '0;
              state_nxt     = S_FILL;
            end
            default: begin
              pos_row_nxt = clamp_row;
              pos_col_nxt = clamp_col;
              state_nxt   = S_ADDR;
            end
          endcase
        end
      end

      // linear cell index from row and column
      S_ADDR: begin
        addr_nxt  = ADDR_W'(pos_row_r) * ADDR_W'(SCREEN_COLS) + ADDR_W'(pos_col_r);
        state_nxt = (req_r == REQ_READ) ? S_RD : S_PUT;
      end

      // write the character unless it is a newline, and advance the cursor
      S_PUT: begin
        if (char_r != NEWLINE_CODE) begin
          ram_we    = 1'b1;
          ram_wdata = {cfg.text_attr, char_r};
        end
        if (wrap) begin
          cur_col_nxt = '0;
          if (pos_row_r == ROW_W'(SCREEN_ROWS - 1)) begin
            cur_row_nxt  = pos_row_r;
            scrolled_nxt = 1'b1;
            addr_nxt     = '0;
            state_nxt    = S_SCR_RD;
          end else begin
            cur_row_nxt = pos_row_r + 1'b1;
            state_nxt   = S_DONE;
          end
        end else begin
          cur_row_nxt = pos_row_r;
          cur_col_nxt = pos_col_r + 1'b1;
          state_nxt   = S_DONE;
        end
      end

      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_RDW;
      end

      S_RDW: begin
        rd_data_nxt = ram_rdata;
        state_nxt   = S_DONE;
      end

      // scroll: fetch the cell one row below
      S_SCR_RD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_sum;
        state_nxt = S_SCR_WR;
      end

      S_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        addr_nxt  = addr_sum;
        if (addr_r == ADDR_W'(CELL_COUNT - SCREEN_COLS - 1)) begin
          fill_val_nxt = '0;
          state_nxt    = S_FILL;
        end else begin
          state_nxt = S_SCR_RD;
        end
      end

      // fill sweep up to the last cell
      S_FILL: begin
        ram_we   = 1'b1;
        addr_nxt = addr_sum;
        if (addr_r == ADDR_W'(CELL_COUNT - 1)) begin
          fill_init_nxt = 1'b0;
          state_nxt     = fill_init_r ? S_IDLE : S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      addr_r      <= '0;
      fill_val_r  <= {RESET_ATTR, SPACE_CODE};
      fill_init_r <= 1'b1;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      fill_val_r  <= fill_val_nxt;
      fill_init_r <= fill_init_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    char_r     <= char_nxt;
    pos_row_r  <= pos_row_nxt;
    pos_col_r  <= pos_col_nxt;
    scrolled_r <= scrolled_nxt;
    rd_data_r  <= rd_data_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  // result fields
  assign res.cursor_row = 5'(cur_row_r);
  assign res.cursor_col = 7'(cur_col_r);
  assign res.read_char  = rd_data_r[7:0];
  assign res.read_attr  = rd_data_r[15:8];
  assign res.scrolled   = scrolled_r;

endmodule

>>> hdl/text_console_writer.sv
// Text console of SCREEN_ROWS x SCREEN_COLS cells (25 x 80 by default), each a character
// byte and an attribute byte, with an internal cursor. One request is taken at a time and
// in_ready stays low until its result has moved into the output register. All cell
// traffic goes through one single-port-write, registered-read cell memory under a small
// sequencer, and the fill and scroll sweeps step through one shared address adder. A put
// computes the cell address, then writes the cell and moves the cursor; a read computes
// the address and then reads the cell; a clear writes one cell per cycle over all the
// SCREEN_ROWS x SCREEN_COLS cells; a put that scrolls then copies each row up (one read
// and one write per cell) and zeroes the bottom row. After reset a clearing pass fills the
// screen with spaces on attribute 0x0F before the first request is taken; configuration
// writes are taken at any time and are meant to happen while no request is in flight.
module text_console_writer #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output tcw_pkg::out_beat_t  out_beat,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  logic [7:0]        text_attr_r, clear_attr_r;
  cfg_t              cfg;
  logic              res_valid;
  logic              res_take;
  out_beat_t         res;
  logic              out_valid_r;
  out_beat_t         out_beat_r;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r  <= RESET_ATTR;
      clear_attr_r <= RESET_ATTR;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEXT_ATTR:  text_attr_r  <= cfg_data;
        CFG_CLEAR_ATTR: clear_attr_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg.text_attr  = text_attr_r;
  assign cfg.clear_attr = clear_attr_r;

  // sequencer
  tcw_ctrl #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // cell store
  tcw_cell_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_beat_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef SYNTH
  // an accepted request leaves the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // a scroll always leaves the cursor at the start of a row
  a_scroll_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.scrolled |-> out_beat.cursor_col == 7'd0)
    else $error("scroll left cursor off column zero");

  // no result is offered while the block is idle
  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("result offered while idle");
`endif

endmodule

>>> dv/text_console_writer_tb.sv
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int CELLS = ROWS * COLS;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } probe_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_beat_t   in_beat;
  logic       out_valid;
  logic       out_ready;
  out_beat_t  out_beat;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // mirror of the console: cells, cursor and the two attribute registers
  logic [15:0] screen [CELLS];
  int unsigned cursor;
  logic [7:0]  text_attr_m;
  logic [7:0]  clear_attr_m;

  out_beat_t   awaited_reports[$];
  int unsigned reports_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned calm_items = 0;

  text_console_writer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // apply one request to the mirror and return the status report it should produce
  function automatic out_beat_t console_step(in_beat_t b);
    out_beat_t   r;
    int unsigned row;
    int unsigned col;
    int unsigned pos;
    r = '0;
    row = (b.row_index > ROWS - 1) ? ROWS - 1 : b.row_index;
    col = (b.col_index > COLS - 1) ? COLS - 1 : b.col_index;
    case (b.req_type)
      REQ_PUT, REQ_PUT_AT: begin
        pos = (b.req_type == REQ_PUT_AT) ? row * COLS + col : cursor;
        if (b.char_code == NEWLINE_CODE) begin
          pos = (pos / COLS + 1) * COLS;
        end else begin
          screen[pos] = {text_attr_m, b.char_code};
          pos++;
        end
        // ran off the end: shift rows up, blank the bottom row with zero bytes
        if (pos >= CELLS) begin
          for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
          pos -= COLS;
          r.scrolled = 1'b1;
        end
        cursor = pos;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = {clear_attr_m, SPACE_CODE};
        cursor = 0;
      end
      default: begin
        {r.read_attr, r.read_char} = screen[row * COLS + col];
      end
    endcase
    r.cursor_row = 5'(cursor / COLS);
    r.cursor_col = 7'(cursor % COLS);
    return r;
  endfunction

  function automatic probe_t probe(logic [1:0] req, logic [7:0] ch, int row, int col,
                                   bit typed = 1'b0, int want_row = 0, int want_col = 0,
                                   logic [7:0] want_char = 8'h00,
                                   logic [7:0] want_attr = 8'h00,
                                   bit want_scroll = 1'b0);
    probe_t p;
    p.beat.req_type = req;
    p.beat.char_code = ch;
    p.beat.row_index = 5'(row);
    p.beat.col_index = 7'(col);
    p.typed = typed;
    p.want.cursor_row = 5'(want_row);
    p.want.cursor_col = 7'(want_col);
    p.want.read_char = want_char;
    p.want.read_attr = want_attr;
    p.want.scrolled = want_scroll;
    return p;
  endfunction

  // mostly puts and reads, some out-of-range positions, few clears
  function automatic in_beat_t random_request();
    in_beat_t    b;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    b.char_code = ($urandom_range(0, 9) == 0) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
    b.row_index = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(0, ROWS - 2));
    b.col_index = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, COLS - 1));
    if (pick < 45) b.req_type = REQ_PUT;
    else if (pick < 70) b.req_type = REQ_PUT_AT;
    else if (pick < 97) b.req_type = REQ_READ;
    else b.req_type = REQ_CLEAR;
    return b;
  endfunction

  // sender idle: mostly none or short, a few long, with calm runs
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_items != 0) begin
      calm_items--;
      return 0;
    end
    if (r < 3) begin
      calm_items = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic offer_request(in_beat_t b, bit typed, out_beat_t want);
    int unsigned gap;
    out_beat_t   mirror_view;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror_view = console_step(b);
    awaited_reports.push_back(typed ? want : mirror_view);
  endtask

  task automatic wait_quiet();
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // both registers, back to back, valid held across the two beats
  task automatic set_attributes(logic [7:0] text_attr, logic [7:0] clear_attr);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TEXT_ATTR;
    cfg_data <= text_attr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    text_attr_m = text_attr;
    cfg_index <= CFG_CLEAR_ATTR;
    cfg_data <= clear_attr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    clear_attr_m = clear_attr;
    cfg_valid <= 1'b0;
  endtask

  // stimulus: reset, directed table, then random phases under changing attributes
  initial begin : stimulus
    probe_t    probes[$];
    out_beat_t none;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TEXT_ATTR;
    cfg_data = '0;
    for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, SPACE_CODE};
    cursor = 0;
    text_attr_m = RESET_ATTR;
    clear_attr_m = RESET_ATTR;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    probes = '{
      probe(REQ_READ, 8'h00, 0, 0, 1, 0, 0, SPACE_CODE, RESET_ATTR),
      probe(REQ_READ, 8'hFF, 31, 127, 1, 0, 0, SPACE_CODE, RESET_ATTR),
      probe(REQ_PUT, 8'h41, 0, 0, 1, 0, 1),
      probe(REQ_PUT, 8'hFF, 31, 127, 1, 0, 2),
      probe(REQ_PUT, 8'h00, 0, 0, 1, 0, 3),
      probe(REQ_READ, 8'h00, 0, 1, 1, 0, 3, 8'hFF, RESET_ATTR),
      probe(REQ_READ, NEWLINE_CODE, 0, 2, 1, 0, 3, 8'h00, RESET_ATTR),
      probe(REQ_PUT, NEWLINE_CODE, 0, 0, 1, 1, 0),
      probe(REQ_PUT_AT, 8'h78, 5, 10, 1, 5, 11),
      // put at the last cell, clamped: scrolls
      probe(REQ_PUT_AT, 8'h55, 31, 127, 1, 24, 0, 8'h00, 8'h00, 1),
      probe(REQ_READ, 8'h00, 23, 79, 1, 24, 0, 8'h55, RESET_ATTR),
      probe(REQ_READ, 8'h00, 24, 5, 1, 24, 0, 8'h00, 8'h00),
      probe(REQ_READ, 8'h00, 4, 10),
      // newline on the bottom row, at the cursor and positioned
      probe(REQ_PUT, NEWLINE_CODE, 0, 0, 1, 24, 0, 8'h00, 8'h00, 1),
      probe(REQ_PUT_AT, NEWLINE_CODE, 24, 100, 1, 24, 0, 8'h00, 8'h00, 1),
      probe(REQ_READ, 8'h00, 21, 79, 1, 24, 0, 8'h55, RESET_ATTR),
      probe(REQ_PUT_AT, 8'h41, 30, 3, 1, 24, 4),
      probe(REQ_PUT_AT, 8'h7E, 0, 127, 1, 1, 0),
      probe(REQ_PUT, 8'h42, 0, 0),
      probe(REQ_CLEAR, NEWLINE_CODE, 31, 127, 1, 0, 0),
      probe(REQ_READ, 8'hAA, 12, 40, 1, 0, 0, SPACE_CODE, RESET_ATTR),
      probe(REQ_PUT_AT, NEWLINE_CODE, 3, 79, 1, 4, 0),
      probe(REQ_READ, 8'h00, 31, 0),
      probe(REQ_CLEAR, 8'hFF, 0, 0, 1, 0, 0)
    };
    foreach (probes[i]) offer_request(probes[i].beat, probes[i].typed, probes[i].want);
    in_valid <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_quiet();
      case (phase)
        0: set_attributes(8'h00, 8'hFF);
        1: set_attributes(8'hFF, 8'h00);
        default: set_attributes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) offer_request(random_request(), 1'b0, none);
      in_valid <= 1'b0;
    end

    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: random stalls, calm runs, and a periodic long hold-off
  initial begin : receiver
    int unsigned hold_left;
    int unsigned calm_left;
    int unsigned next_squeeze;
    int unsigned r;
    hold_left = 0;
    calm_left = 0;
    next_squeeze = 150;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (reports_seen >= next_squeeze) begin
        // long hold-off so the block backs up and stalls its input
        next_squeeze += 900;
        hold_left = 400;
        out_ready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else if (r < 4) begin
        calm_left = $urandom_range(20, 80);
        out_ready <= 1'b1;
      end else if (r < 20) begin
        hold_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else if (r < 22) begin
        hold_left = $urandom_range(20, 60);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic flag_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare each report beat with the oldest pending expectation
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      reports_seen++;
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %p", $time, out_beat);
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        flag_field("cursor_row", want.cursor_row, out_beat.cursor_row);
        flag_field("cursor_col", want.cursor_col, out_beat.cursor_col);
        flag_field("read_char", want.read_char, out_beat.read_char);
        flag_field("read_attr", want.read_attr, out_beat.read_attr);
        flag_field("scrolled", want.scrolled, out_beat.scrolled);
      end
    end
  end

  // watchdog on cycles with no beat moving on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
